>>> rtl/ntc_average_and_interpolate_defines.svh
// Assertion macros shared by the thermistor averaging block.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef NTC_AVERAGE_AND_INTERPOLATE_DEFINES_SVH
`define NTC_AVERAGE_AND_INTERPOLATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NTC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ntc_pkg.sv
// Package for the thermistor averaging block: thermistor table, widths,
// job and status structs and the back-end state type. No dependencies.
package ntc_pkg;

  localparam int CHANNELS_DEF    = 2;
  localparam int AVG_LOG2_DEF    = 4;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int NTC_POINTS  = 11;
  localparam int CODE_W      = 12;
  localparam int SEG_W       = 4;
  localparam int DEN_W       = 10;
  localparam int TEMP_W      = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CODE_W-1:0] NTC_FLOOR = 12'd80;

  localparam logic signed [TEMP_W-1:0] NTC_DEG [NTC_POINTS] =
    '{-8'sd20, -8'sd10, 8'sd0, 8'sd10, 8'sd20, 8'sd30, 8'sd40, 8'sd50, 8'sd60, 8'sd70,
      8'sd80};

  localparam logic [CODE_W-1:0] NTC_CODE [NTC_POINTS] =
    '{12'd2455, 12'd1922, 12'd1413, 12'd1007, 12'd688, 12'd474, 12'd322, 12'd224,
      12'd157, 12'd110, 12'd80};

  // Code span of one segment; the largest span is 533, so ten bits suffice.
  function automatic logic [DEN_W-1:0] seg_den(input logic [SEG_W-1:0] seg);
    logic [CODE_W-1:0] diff;
    diff = NTC_CODE[seg] - NTC_CODE[seg + 1'b1];
    return diff[DEN_W-1:0];
  endfunction

  typedef struct packed {
    logic             ch;
    logic             neg;
    logic [SEG_W-1:0] seg;
  } ntc_job_t;

  typedef struct packed {
    logic avg_pending;
  } ntc_front_stat_t;

  typedef struct packed {
    logic busy;
    logic load;
  } ntc_back_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } ntc_bk_state_t;

endpackage

>>> rtl/ntc_average_and_interpolate.sv
// Top level of the thermistor averaging and temperature lookup block.
// Depends on ntc_pkg, ntc_front, ntc_queue, ntc_back and the defines header.

// Samples arrive tagged with a channel and are accepted at one transaction
// per clock while the front end is free. Each channel adds up 2^AVG_LOG2
// samples; the last sample of a group forms the average, clears that
// channel's sum and count, and issues one temperature result. Samples on a
// channel number at or above CHANNELS are accepted and discarded. The average
// is clamped to at least 80, placed in one of the ten segments of an
// 11-point thermistor table running from -20 C to 80 C, and interpolated
// linearly with the quotient truncated toward zero; averages above the top
// code extrapolate along the first segment. The result is an 8-bit two's
// complement temperature in degrees Celsius. A conversion occupies the back
// end from taking a job through loading its result, and the restoring
// divider produces one quotient bit per cycle of an N-bit quotient, where
// N = max(SAMPLE_BITS, 12) + 4. A two-entry job queue and a pending
// average register sit between the front and back ends, so samples keep
// flowing at one per cycle unless completed groups arrive faster than one
// per conversion time, in which case in_ready drops until the queue drains.
// The output register lets the back end carry out the next division while a
// result still waits on out_ready.
`include "ntc_average_and_interpolate_defines.svh"

module ntc_average_and_interpolate #(
  parameter int CHANNELS    = ntc_pkg::CHANNELS_DEF,
  parameter int AVG_LOG2    = ntc_pkg::AVG_LOG2_DEF,
  parameter int SAMPLE_BITS = ntc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_channel,
  input  logic [SAMPLE_BITS-1:0]            in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_channel,
  output logic signed [ntc_pkg::TEMP_W-1:0] out_temperature
);

  // Width of the comparison path and of the scaled dividend.
  localparam int V_W   = (SAMPLE_BITS > ntc_pkg::CODE_W) ? SAMPLE_BITS : ntc_pkg::CODE_W;
  localparam int N_W   = V_W + 4;
  localparam int JOB_W = $bits(ntc_pkg::ntc_job_t) + N_W;

  logic                     push, push_ready;
  logic                     pop, pop_valid;
  ntc_pkg::ntc_job_t        wr_job, rd_job;
  logic [N_W-1:0]           wr_n, rd_n;
  logic [JOB_W-1:0]         rd_data;
  ntc_pkg::ntc_front_stat_t fr_stat;
  ntc_pkg::ntc_back_stat_t  bk_stat;

  // The front end accumulates samples and classifies each finished average.
  ntc_front #(
    .CHANNELS    (CHANNELS),
    .AVG_LOG2    (AVG_LOG2),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_channel (in_channel),
    .in_sample  (in_sample),
    .q_push     (push),
    .q_ready    (push_ready),
    .q_job      (wr_job),
    .q_n        (wr_n),
    .stat       (fr_stat)
  );

  // The queue decouples classification from the multi-cycle division.
  ntc_queue #(
    .WIDTH (JOB_W),
    .DEPTH (ntc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .wr_data    ({wr_job, wr_n}),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .rd_data    (rd_data)
  );

  assign {rd_job, rd_n} = rd_data;

  // The back end divides, applies the segment's base temperature and holds
  // the result until it is taken.
  ntc_back #(
    .N_W (N_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (pop_valid),
    .q_pop           (pop),
    .q_job           (rd_job),
    .q_n             (rd_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_temperature (out_temperature),
    .stat            (bk_stat)
  );

  // A job taken from the queue keeps the back end busy in the next cycle.
  `NTC_ASSERT_NXT(a_pop_starts_work, pop, bk_stat.busy, "back end idle after taking a job")
  // A result only appears after the back end has loaded the output register.
  `NTC_ASSERT_IMP(a_result_from_load, $rose(out_valid), $past(bk_stat.load),
                  "result appeared without a load")
  // The input stalls only while an average waits for room in the queue.
  `NTC_ASSERT_IMP(a_stall_cause, !in_ready, fr_stat.avg_pending && !push_ready,
                  "input stalled without a pending average and a full queue")

endmodule

>>> rtl/ntc_front.sv
// Front end: per-channel accumulation, averaging and segment classification.
// Depends on ntc_pkg; feeds jobs into ntc_queue.
module ntc_front #(
  parameter int CHANNELS    = ntc_pkg::CHANNELS_DEF,
  parameter int AVG_LOG2    = ntc_pkg::AVG_LOG2_DEF,
  parameter int SAMPLE_BITS = ntc_pkg::SAMPLE_BITS_DEF,
  localparam int V_W        = (SAMPLE_BITS > ntc_pkg::CODE_W) ? SAMPLE_BITS : ntc_pkg::CODE_W,
  localparam int N_W        = V_W + 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_channel,
  input  logic [SAMPLE_BITS-1:0]   in_sample,
  output logic                     q_push,
  input  logic                     q_ready,
  output ntc_pkg::ntc_job_t        q_job,
  output logic [N_W-1:0]           q_n,
  output ntc_pkg::ntc_front_stat_t stat
);

  localparam int SUM_W = SAMPLE_BITS + AVG_LOG2;
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [SUM_W-1:0]       sum_r [CHANNELS];
  logic [SUM_W-1:0]       sum_nxt [CHANNELS];
  logic [AVG_LOG2-1:0]    cnt_r [CHANNELS];
  logic [AVG_LOG2-1:0]    cnt_nxt [CHANNELS];
  logic [SAMPLE_BITS-1:0] avg_r, avg_nxt;
  logic                   avg_vld_r, avg_vld_nxt;
  logic                   avg_ch_r, avg_ch_nxt;

  logic                   accept;
  logic                   ch_ok;
  logic [CH_W-1:0]        idx;
  logic [SUM_W-1:0]       sum_add;

  logic [V_W-1:0]              v;
  logic [V_W-1:0]              code_seg;
  logic [V_W-1:0]              a;
  logic [ntc_pkg::SEG_W-1:0]   seg;
  logic                        neg;

  assign q_push   = avg_vld_r && q_ready;
  assign in_ready = !avg_vld_r || q_push;
  assign accept   = in_valid && in_ready;
  assign ch_ok    = int'(in_channel) < CHANNELS;
  assign idx      = CH_W'(in_channel);
  assign sum_add  = sum_r[idx] + SUM_W'(in_sample);
  assign stat.avg_pending = avg_vld_r;

  always_comb begin
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    avg_nxt     = avg_r;
    avg_ch_nxt  = avg_ch_r;
    avg_vld_nxt = avg_vld_r && !q_push;
    if (accept && ch_ok) begin
      if (cnt_r[idx] == {AVG_LOG2{1'b1}}) begin
        // Last sample of the group: form the average and restart the group.
        sum_nxt[idx] = '0;
        cnt_nxt[idx] = '0;
        avg_nxt      = sum_add[SUM_W-1:AVG_LOG2];
        avg_ch_nxt   = in_channel;
        avg_vld_nxt  = 1'b1;
      end else begin
        sum_nxt[idx] = sum_add;
        cnt_nxt[idx] = cnt_r[idx] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CHANNELS; k++) begin
        sum_r[k] <= '0;
        cnt_r[k] <= '0;
      end
      avg_vld_r <= 1'b0;
    end else begin
      sum_r     <= sum_nxt;
      cnt_r     <= cnt_nxt;
      avg_vld_r <= avg_vld_nxt;
    end
    avg_r    <= avg_nxt;
    avg_ch_r <= avg_ch_nxt;
  end

  // Classification: clamp, pick the first segment whose lower code is at or
  // below the average, and form ten times the distance from its upper code.
  always_comb begin
    v = V_W'(avg_r);
    if (v < V_W'(ntc_pkg::NTC_FLOOR)) begin
      v = V_W'(ntc_pkg::NTC_FLOOR);
    end
    seg = ntc_pkg::SEG_W'(ntc_pkg::NTC_POINTS - 2);
    for (int i = ntc_pkg::NTC_POINTS - 2; i >= 0; i--) begin
      if (v >= V_W'(ntc_pkg::NTC_CODE[i + 1])) begin
        seg = ntc_pkg::SEG_W'(i);
      end
    end
    code_seg = V_W'(ntc_pkg::NTC_CODE[seg]);
    neg      = v > code_seg;
    a        = neg ? (v - code_seg) : (code_seg - v);
  end

  assign q_n       = (N_W'(a) << 3) + (N_W'(a) << 1);
  assign q_job.ch  = avg_ch_r;
  assign q_job.neg = neg;
  assign q_job.seg = seg;

endmodule

>>> rtl/ntc_queue.sv
// Short first-in first-out queue of jobs between the front and back ends.
// Depends on nothing; the payload is a flat vector.
module ntc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/ntc_back.sv
// Back end: restoring divider, one quotient bit per cycle, and output register.
// Depends on ntc_pkg; takes jobs from ntc_queue.
module ntc_back #(
  parameter int N_W = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  ntc_pkg::ntc_job_t                 q_job,
  input  logic [N_W-1:0]                    q_n,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_channel,
  output logic signed [ntc_pkg::TEMP_W-1:0] out_temperature,
  output ntc_pkg::ntc_back_stat_t           stat
);

  localparam int CNT_W = $clog2(N_W);
  localparam int R_W   = N_W + 1;
  localparam int D_W   = ntc_pkg::DEN_W;

  ntc_pkg::ntc_bk_state_t state_r, state_nxt;
  ntc_pkg::ntc_job_t      job_r, job_nxt;
  logic [N_W-1:0]         quo_r, quo_nxt;
  logic [D_W-1:0]         rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_ch_r, out_ch_nxt;
  logic [ntc_pkg::TEMP_W-1:0] out_temp_r, out_temp_nxt;

  logic                   pop, step, load, last;
  logic [D_W-1:0]         den;
  logic [D_W:0]           rem_sh;
  logic                   ge;
  logic signed [R_W-1:0]  deg_x, quo_x, res;

  assign den    = ntc_pkg::seg_den(job_r.seg);
  assign rem_sh = {rem_r, quo_r[N_W-1]};
  assign ge     = rem_sh >= {1'b0, den};
  assign last   = cnt_r == CNT_W'(N_W - 1);
  assign deg_x  = R_W'(ntc_pkg::NTC_DEG[job_r.seg]);
  assign quo_x  = signed'({1'b0, quo_r});
  assign res    = job_r.neg ? (deg_x - quo_x) : (deg_x + quo_x);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ntc_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_nxt = ntc_pkg::BK_RUN;
        end
      end
      ntc_pkg::BK_RUN: begin
        if (last) begin
          state_nxt = ntc_pkg::BK_DONE;
        end
      end
      ntc_pkg::BK_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ntc_pkg::BK_IDLE;
        end
      end
      default: state_nxt = ntc_pkg::BK_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    pop  = 1'b0;
    step = 1'b0;
    load = 1'b0;
    case (state_r)
      ntc_pkg::BK_IDLE: pop  = q_valid;
      ntc_pkg::BK_RUN:  step = 1'b1;
      ntc_pkg::BK_DONE: load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_comb begin
    job_nxt       = job_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_ch_nxt    = out_ch_r;
    out_temp_nxt  = out_temp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (pop) begin
      job_nxt = q_job;
      quo_nxt = q_n;
      rem_nxt = '0;
      cnt_nxt = '0;
    end
    if (step) begin
      rem_nxt = ge ? D_W'(rem_sh - {1'b0, den}) : rem_sh[D_W-1:0];
      quo_nxt = {quo_r[N_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
    end
    if (load) begin
      out_ch_nxt    = job_r.ch;
      out_temp_nxt  = res[ntc_pkg::TEMP_W-1:0];
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ntc_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r      <= job_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_ch_r   <= out_ch_nxt;
    out_temp_r <= out_temp_nxt;
  end

  assign q_pop           = pop;
  assign out_valid       = out_valid_r;
  assign out_channel     = out_ch_r;
  assign out_temperature = signed'(out_temp_r);
  assign stat.busy       = state_r != ntc_pkg::BK_IDLE;
  assign stat.load       = load;

endmodule
